>>> rtl/core/fwprc_pkg.sv
// shared types, codes and command decoder for the four wheel pwm ramp controller
`timescale 1ns / 1ps

package fwprc_pkg;

  localparam int DUTY_WIDTH_DEF = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 10;
  localparam int NUM_WHEELS     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_DEFAULT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSED_MASK  = 3'd5;

  localparam logic [7:0] RST_RAMP_STEP      = 8'd5;
  localparam logic [9:0] RST_RAMP_PERIOD_MS = 10'd10;
  localparam logic [7:0] RST_SPEED_DEFAULT  = 8'd200;
  localparam logic [7:0] RST_ROTATE_SPEED   = 8'd150;
  localparam logic [7:0] RST_DIAGONAL_SPEED = 8'd200;
  localparam logic [3:0] RST_REVERSED_MASK  = 4'd0;

  localparam logic [9:0] MS_MAX = 10'd1023;

  localparam logic [7:0] CMD_F = 8'h46;
  localparam logic [7:0] CMD_B = 8'h42;
  localparam logic [7:0] CMD_Q = 8'h51;
  localparam logic [7:0] CMD_E = 8'h45;
  localparam logic [7:0] CMD_S = 8'h53;
  localparam logic [7:0] CMD_L = 8'h4C;
  localparam logic [7:0] CMD_R = 8'h52;
  localparam logic [7:0] CMD_G = 8'h47;
  localparam logic [7:0] CMD_H = 8'h48;
  localparam logic [7:0] CMD_J = 8'h4A;
  localparam logic [7:0] CMD_K = 8'h4B;

  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    SPD_DEFAULT = 2'd0,
    SPD_ROTATE  = 2'd1,
    SPD_DIAG    = 2'd2
  } spd_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] command_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] fl_fwd_duty;
    logic [7:0] fl_back_duty;
    logic [7:0] fr_fwd_duty;
    logic [7:0] fr_back_duty;
    logic [7:0] rl_fwd_duty;
    logic [7:0] rl_back_duty;
    logic [7:0] rr_fwd_duty;
    logic [7:0] rr_back_duty;
    logic       cmd_ok;
  } out_t;

  // per wheel control for one processed item
  typedef struct packed {
    logic       stop;
    logic       set;
    logic       ramp;
    dir_t       dir;
    logic [7:0] duty;
    logic [7:0] step;
  } wheel_ctl_t;

  typedef struct packed {
    logic                  ok;
    logic                  stop;
    spd_t                  spd;
    dir_t [NUM_WHEELS-1:0] dirs;
  } decode_t;

  // dirs index 0 front left, 1 front right, 2 rear left, 3 rear right
  function automatic decode_t decode_cmd(input logic [7:0] byte_in);
    logic [7:0] c;
    decode_t    d;
    c = byte_in;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      c = c - CASE_DELTA;
    end
    d.ok   = 1'b1;
    d.stop = 1'b0;
    d.spd  = SPD_DEFAULT;
    d.dirs = {DIR_STOP, DIR_STOP, DIR_STOP, DIR_STOP};
    case (c)
      CMD_F: d.dirs = {DIR_FWD, DIR_FWD, DIR_FWD, DIR_FWD};
      CMD_B: d.dirs = {DIR_BACK, DIR_BACK, DIR_BACK, DIR_BACK};
      CMD_Q: begin
        d.dirs = {DIR_FWD, DIR_BACK, DIR_FWD, DIR_BACK};
        d.spd  = SPD_ROTATE;
      end
      CMD_E: begin
        d.dirs = {DIR_BACK, DIR_FWD, DIR_BACK, DIR_FWD};
        d.spd  = SPD_ROTATE;
      end
      CMD_S: d.stop = 1'b1;
      CMD_L: d.dirs = {DIR_BACK, DIR_FWD, DIR_FWD, DIR_BACK};
      CMD_R: d.dirs = {DIR_FWD, DIR_BACK, DIR_BACK, DIR_FWD};
      CMD_G: begin
        d.dirs = {DIR_FWD, DIR_STOP, DIR_STOP, DIR_FWD};
        d.spd  = SPD_DIAG;
      end
      CMD_H: begin
        d.dirs = {DIR_STOP, DIR_FWD, DIR_FWD, DIR_STOP};
        d.spd  = SPD_DIAG;
      end
      CMD_J: d.dirs = {DIR_STOP, DIR_BACK, DIR_BACK, DIR_STOP};
      CMD_K: d.dirs = {DIR_BACK, DIR_STOP, DIR_STOP, DIR_BACK};
      default: begin
        d.ok   = 1'b0;
        d.stop = 1'b1;
      end
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/fwprc_wheel.sv
// one wheel: target and applied direction, duty slew and channel mapping
`timescale 1ns / 1ps

module fwprc_wheel #(
  parameter int DUTY_WIDTH = fwprc_pkg::DUTY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fwprc_pkg::wheel_ctl_t  ctl,
  input  logic                   rev,
  output logic [7:0]             fwd_duty,
  output logic [7:0]             back_duty
);
  import fwprc_pkg::*;

  dir_t                  tdir_r, tdir_nxt;
  dir_t                  adir_r, adir_nxt;
  logic [DUTY_WIDTH-1:0] tduty_r, tduty_nxt;
  logic [DUTY_WIDTH-1:0] cduty_r, cduty_nxt;

  logic                  flip;
  logic [DUTY_WIDTH-1:0] goal;
  logic [DUTY_WIDTH-1:0] step_ext;
  logic [DUTY_WIDTH-1:0] ramped;
  logic                  forward;

  assign step_ext = DUTY_WIDTH'(ctl.step);
  assign flip     = (tdir_r != adir_r) && (tdir_r != DIR_STOP);
  assign goal     = flip ? '0 : tduty_r;

  // step toward the goal without passing it
  always_comb begin
    ramped = cduty_r;
    if (cduty_r < goal) begin
      ramped = ((goal - cduty_r) <= step_ext) ? goal : cduty_r + step_ext;
    end else if (cduty_r > goal) begin
      ramped = ((cduty_r - goal) <= step_ext) ? goal : cduty_r - step_ext;
    end
  end

  always_comb begin
    tdir_nxt  = tdir_r;
    adir_nxt  = adir_r;
    tduty_nxt = tduty_r;
    cduty_nxt = cduty_r;
    if (ctl.stop) begin
      tdir_nxt  = DIR_STOP;
      adir_nxt  = DIR_STOP;
      tduty_nxt = '0;
      cduty_nxt = '0;
    end else if (ctl.set) begin
      tdir_nxt  = ctl.dir;
      tduty_nxt = (ctl.dir == DIR_STOP) ? '0 : DUTY_WIDTH'(ctl.duty);
    end else if (ctl.ramp) begin
      cduty_nxt = ramped;
      if (ramped == '0) begin
        adir_nxt = tdir_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdir_r  <= DIR_STOP;
      adir_r  <= DIR_STOP;
      tduty_r <= '0;
      cduty_r <= '0;
    end else begin
      tdir_r  <= tdir_nxt;
      adir_r  <= adir_nxt;
      tduty_r <= tduty_nxt;
      cduty_r <= cduty_nxt;
    end
  end

  assign forward = (adir_nxt == DIR_FWD) ^ rev;

  always_comb begin
    fwd_duty  = '0;
    back_duty = '0;
    if (adir_nxt == DIR_FWD || adir_nxt == DIR_BACK) begin
      if (forward) begin
        fwd_duty = cduty_nxt[7:0];
      end else begin
        back_duty = cduty_nxt[7:0];
      end
    end
  end

endmodule

>>> rtl/core/four_wheel_pwm_ramp_controller.sv
// top level of the four wheel pwm ramp controller
// throughput: one item per cycle unless a held result is stalled, set by the single registered update pass
// reset: synchronous active low; all wheels stopped, duties and tick count zero,
// registers back to their defaults
`timescale 1ns / 1ps

module four_wheel_pwm_ramp_controller #(
  parameter int DUTY_WIDTH = fwprc_pkg::DUTY_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fwprc_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fwprc_pkg::out_t                     out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fwprc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fwprc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fwprc_pkg::*;

  logic [7:0] ramp_step_r;
  logic [9:0] ramp_period_r;
  logic [7:0] speed_default_r;
  logic [7:0] rotate_speed_r;
  logic [7:0] diagonal_speed_r;
  logic [3:0] reversed_mask_r;

  logic in_vld_r, in_vld_nxt;
  in_t  in_data_r;
  logic out_vld_r, out_vld_nxt;
  out_t out_data_r;
  logic [9:0] ms_r, ms_nxt;

  logic       in_xfer;
  logic       advance;
  logic       is_tick;
  logic [9:0] ms_inc;
  logic       ramp_now;
  decode_t    dec;
  logic [7:0] sel_duty;

  wheel_ctl_t ctl [NUM_WHEELS];
  logic [7:0] fwd [NUM_WHEELS];
  logic [7:0] back [NUM_WHEELS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r      <= RST_RAMP_STEP;
      ramp_period_r    <= RST_RAMP_PERIOD_MS;
      speed_default_r  <= RST_SPEED_DEFAULT;
      rotate_speed_r   <= RST_ROTATE_SPEED;
      diagonal_speed_r <= RST_DIAGONAL_SPEED;
      reversed_mask_r  <= RST_REVERSED_MASK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RAMP_STEP:      ramp_step_r      <= cfg_data[7:0];
        REG_RAMP_PERIOD_MS: ramp_period_r    <= cfg_data[9:0];
        REG_SPEED_DEFAULT:  speed_default_r  <= cfg_data[7:0];
        REG_ROTATE_SPEED:   rotate_speed_r   <= cfg_data[7:0];
        REG_DIAGONAL_SPEED: diagonal_speed_r <= cfg_data[7:0];
        REG_REVERSED_MASK:  reversed_mask_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input register feeds the update pass, result register holds its output
  assign advance    = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall   = in_vld_r && !advance;
  assign in_xfer    = in_valid && !in_stall;
  assign in_vld_nxt = in_xfer ? 1'b1 : (advance ? 1'b0 : in_vld_r);
  assign out_vld_nxt = advance ? 1'b1 : ((out_vld_r && !out_stall) ? 1'b0 : out_vld_r);

  assign is_tick  = in_data_r.req_type;
  assign ms_inc   = (ms_r < MS_MAX) ? ms_r + 10'd1 : ms_r;
  assign ramp_now = ms_inc >= ramp_period_r;
  assign dec      = decode_cmd(in_data_r.command_byte);

  always_comb begin
    ms_nxt = ms_r;
    if (advance && is_tick) begin
      ms_nxt = ramp_now ? 10'd0 : ms_inc;
    end
  end

  always_comb begin
    case (dec.spd)
      SPD_DEFAULT: sel_duty = speed_default_r;
      SPD_ROTATE:  sel_duty = rotate_speed_r;
      SPD_DIAG:    sel_duty = diagonal_speed_r;
      default:     sel_duty = speed_default_r;
    endcase
  end

  for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
    always_comb begin
      ctl[w].stop = advance && !is_tick && dec.stop;
      ctl[w].set  = advance && !is_tick && !dec.stop;
      ctl[w].ramp = advance && is_tick && ramp_now;
      ctl[w].dir  = dec.dirs[w];
      ctl[w].duty = sel_duty;
      ctl[w].step = ramp_step_r;
    end

    fwprc_wheel #(
      .DUTY_WIDTH(DUTY_WIDTH)
    ) u_wheel (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[w]),
      .rev       (reversed_mask_r[w]),
      .fwd_duty  (fwd[w]),
      .back_duty (back[w])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ms_r      <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      ms_r      <= ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.fl_fwd_duty  <= fwd[0];
      out_data_r.fl_back_duty <= back[0];
      out_data_r.fr_fwd_duty  <= fwd[1];
      out_data_r.fr_back_duty <= back[1];
      out_data_r.rl_fwd_duty  <= fwd[2];
      out_data_r.rl_back_duty <= back[2];
      out_data_r.rr_fwd_duty  <= fwd[3];
      out_data_r.rr_back_duty <= back[3];
      out_data_r.cmd_ok       <= !is_tick && dec.ok;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a wheel never drives both of its channels
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !((out_data_r.fl_fwd_duty != 8'd0 && out_data_r.fl_back_duty != 8'd0) ||
                    (out_data_r.fr_fwd_duty != 8'd0 && out_data_r.fr_back_duty != 8'd0) ||
                    (out_data_r.rl_fwd_duty != 8'd0 && out_data_r.rl_back_duty != 8'd0) ||
                    (out_data_r.rr_fwd_duty != 8'd0 && out_data_r.rr_back_duty != 8'd0)))
    else $error("wheel drives both channels");

  // a tick result never reports a recognized command
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_tick |=> out_vld_r && !out_data_r.cmd_ok)
    else $error("tick result with cmd_ok set");

  // input stalls only while both stages are occupied and the result is held
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

>>> sim/tb.sv
// self-checking testbench for the four wheel pwm ramp controller: directed and random traffic
`timescale 1ns / 1ps

module tb;
  import fwprc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic REQ_CMD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  four_wheel_pwm_ramp_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // drive state kept by the testbench, wheel 0 front left .. 3 rear right
  logic [7:0] slew_step = RST_RAMP_STEP;
  logic [9:0] slew_period = RST_RAMP_PERIOD_MS;
  logic [7:0] duty_straight = RST_SPEED_DEFAULT;
  logic [7:0] duty_rotate = RST_ROTATE_SPEED;
  logic [7:0] duty_diag = RST_DIAGONAL_SPEED;
  logic [3:0] swap_mask = RST_REVERSED_MASK;
  dir_t wheel_goal_dir [NUM_WHEELS] = '{DIR_STOP, DIR_STOP, DIR_STOP, DIR_STOP};
  dir_t wheel_dir [NUM_WHEELS] = '{DIR_STOP, DIR_STOP, DIR_STOP, DIR_STOP};
  logic [7:0] wheel_goal_duty [NUM_WHEELS] = '{8'd0, 8'd0, 8'd0, 8'd0};
  logic [7:0] wheel_duty [NUM_WHEELS] = '{8'd0, 8'd0, 8'd0, 8'd0};
  logic [9:0] ticks_since_slew = '0;

  out_t expected_duties [$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void halt_wheels();
    for (int w = 0; w < NUM_WHEELS; w++) begin
      wheel_goal_dir[w] = DIR_STOP;
      wheel_dir[w] = DIR_STOP;
      wheel_goal_duty[w] = 8'd0;
      wheel_duty[w] = 8'd0;
    end
  endfunction

  function automatic logic take_command(input logic [7:0] raw);
    logic [7:0] c;
    logic [7:0] duty;
    dir_t dirs [NUM_WHEELS];
    c = raw;
    if (raw >= LOWER_A && raw <= LOWER_Z) begin
      c = raw - CASE_DELTA;
    end
    duty = duty_straight;
    case (c)
      CMD_F: dirs = '{DIR_FWD, DIR_FWD, DIR_FWD, DIR_FWD};
      CMD_B: dirs = '{DIR_BACK, DIR_BACK, DIR_BACK, DIR_BACK};
      CMD_Q: begin
        dirs = '{DIR_BACK, DIR_FWD, DIR_BACK, DIR_FWD};
        duty = duty_rotate;
      end
      CMD_E: begin
        dirs = '{DIR_FWD, DIR_BACK, DIR_FWD, DIR_BACK};
        duty = duty_rotate;
      end
      CMD_L: dirs = '{DIR_BACK, DIR_FWD, DIR_FWD, DIR_BACK};
      CMD_R: dirs = '{DIR_FWD, DIR_BACK, DIR_BACK, DIR_FWD};
      CMD_G: begin
        dirs = '{DIR_FWD, DIR_STOP, DIR_STOP, DIR_FWD};
        duty = duty_diag;
      end
      CMD_H: begin
        dirs = '{DIR_STOP, DIR_FWD, DIR_FWD, DIR_STOP};
        duty = duty_diag;
      end
      CMD_J: dirs = '{DIR_STOP, DIR_BACK, DIR_BACK, DIR_STOP};
      CMD_K: dirs = '{DIR_BACK, DIR_STOP, DIR_STOP, DIR_BACK};
      CMD_S: begin
        halt_wheels();
        return 1'b1;
      end
      default: begin
        halt_wheels();
        return 1'b0;
      end
    endcase
    for (int w = 0; w < NUM_WHEELS; w++) begin
      wheel_goal_dir[w] = dirs[w];
      wheel_goal_duty[w] = (dirs[w] == DIR_STOP) ? 8'd0 : duty;
    end
    return 1'b1;
  endfunction

  function automatic void slew_wheels();
    int goal;
    int cur;
    int step;
    step = slew_step;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      // a pending reversal heads for zero first
      if (wheel_goal_dir[w] != wheel_dir[w] && wheel_goal_dir[w] != DIR_STOP) begin
        goal = 0;
      end else begin
        goal = wheel_goal_duty[w];
      end
      cur = wheel_duty[w];
      if (cur < goal) begin
        cur = (goal - cur <= step) ? goal : cur + step;
      end else if (cur > goal) begin
        cur = (cur - goal <= step) ? goal : cur - step;
      end
      wheel_duty[w] = cur[7:0];
      if (cur == 0) begin
        wheel_dir[w] = wheel_goal_dir[w];
      end
    end
  endfunction

  function automatic out_t predict_channel_duties(input in_t item);
    out_t r;
    logic ok;
    logic forward;
    logic [7:0] fwd [NUM_WHEELS];
    logic [7:0] back [NUM_WHEELS];
    ok = 1'b0;
    if (item.req_type == REQ_CMD) begin
      ok = take_command(item.command_byte);
    end else begin
      if (ticks_since_slew < MS_MAX) begin
        ticks_since_slew = ticks_since_slew + 10'd1;
      end
      if (ticks_since_slew >= slew_period) begin
        ticks_since_slew = '0;
        slew_wheels();
      end
    end
    for (int w = 0; w < NUM_WHEELS; w++) begin
      fwd[w] = 8'd0;
      back[w] = 8'd0;
      if (wheel_dir[w] != DIR_STOP) begin
        forward = (wheel_dir[w] == DIR_FWD) ^ swap_mask[w];
        if (forward) begin
          fwd[w] = wheel_duty[w];
        end else begin
          back[w] = wheel_duty[w];
        end
      end
    end
    r.fl_fwd_duty = fwd[0];
    r.fl_back_duty = back[0];
    r.fr_fwd_duty = fwd[1];
    r.fr_back_duty = back[1];
    r.rl_fwd_duty = fwd[2];
    r.rl_back_duty = back[2];
    r.rr_fwd_duty = fwd[3];
    r.rr_back_duty = back[3];
    r.cmd_ok = ok;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_duties.size() == 0) begin
      report_mismatch("result with nothing outstanding", 0, 0);
      return;
    end
    want = expected_duties.pop_front();
    if ($isunknown(got)) begin
      report_mismatch("unknown bits in result", 0, 0);
    end
    check_field("fl_fwd_duty", got.fl_fwd_duty, want.fl_fwd_duty);
    check_field("fl_back_duty", got.fl_back_duty, want.fl_back_duty);
    check_field("fr_fwd_duty", got.fr_fwd_duty, want.fr_fwd_duty);
    check_field("fr_back_duty", got.fr_back_duty, want.fr_back_duty);
    check_field("rl_fwd_duty", got.rl_fwd_duty, want.rl_fwd_duty);
    check_field("rl_back_duty", got.rl_back_duty, want.rl_back_duty);
    check_field("rr_fwd_duty", got.rr_fwd_duty, want.rr_fwd_duty);
    check_field("rr_back_duty", got.rr_back_duty, want.rr_back_duty);
    check_field("cmd_ok", got.cmd_ok, want.cmd_ok);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_result(out_data);
    end
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // valid stays high after a transfer until the next call decides
  task automatic send_item(input in_t item);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    expected_duties.push_back(predict_channel_duties(item));
    items_sent++;
  endtask

  task automatic send_command(input logic [7:0] code);
    in_t item;
    item.req_type = REQ_CMD;
    item.command_byte = code;
    send_item(item);
  endtask

  task automatic send_ticks(input int n);
    in_t item;
    repeat (n) begin
      item.req_type = REQ_TICK;
      item.command_byte = 8'($urandom);
      send_item(item);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
  endtask

  // writes every register in turn, only while nothing is outstanding
  task automatic configure(input logic [7:0] step, input logic [9:0] period,
                           input logic [7:0] spd_straight, input logic [7:0] spd_rotate,
                           input logic [7:0] spd_diag, input logic [3:0] mask);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [CFG_DATA_W-1:0] values [6];
    wait_drained();
    idx[0] = REG_RAMP_STEP;
    idx[1] = REG_RAMP_PERIOD_MS;
    idx[2] = REG_SPEED_DEFAULT;
    idx[3] = REG_ROTATE_SPEED;
    idx[4] = REG_DIAGONAL_SPEED;
    idx[5] = REG_REVERSED_MASK;
    values[0] = CFG_DATA_W'(step);
    values[1] = period;
    values[2] = CFG_DATA_W'(spd_straight);
    values[3] = CFG_DATA_W'(spd_rotate);
    values[4] = CFG_DATA_W'(spd_diag);
    values[5] = CFG_DATA_W'(mask);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= values[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    slew_step = step;
    slew_period = period;
    duty_straight = spd_straight;
    duty_rotate = spd_rotate;
    duty_diag = spd_diag;
    swap_mask = mask;
  endtask

  function automatic logic [7:0] pick_motion(input int k);
    case (k)
      0: return CMD_F;
      1: return CMD_B;
      2: return CMD_Q;
      3: return CMD_E;
      4: return CMD_L;
      5: return CMD_R;
      6: return CMD_G;
      7: return CMD_H;
      8: return CMD_J;
      default: return CMD_K;
    endcase
  endfunction

  // defaults after reset: one ramp period of ten ticks moves the duty by five
  task automatic test_reset_defaults();
    send_command(CMD_F);
    send_ticks(10);
  endtask

  // every letter but F, case folding, stop and unknown bytes, zero ramp period
  task automatic test_command_decode();
    configure(8'd255, 10'd0, 8'd200, 8'd150, 8'd180, 4'h0);
    send_command(CMD_B | CASE_DELTA);
    send_ticks(2);
    send_command(CMD_Q | CASE_DELTA);
    send_ticks(1);
    send_command(CMD_E);
    send_command(CMD_L | CASE_DELTA);
    send_ticks(1);
    send_command(CMD_R);
    send_command(CMD_G);
    send_ticks(1);
    send_command(CMD_H | CASE_DELTA);
    send_command(CMD_J);
    send_ticks(1);
    send_command(CMD_K);
    send_command(CMD_S | CASE_DELTA);
    send_command(8'h00);
    send_command(8'hFF);
    send_command(LOWER_Z + 8'd1);
  endtask

  // tick count survives a stop, and a shorter period fires on the next tick
  task automatic test_period_change();
    configure(8'd7, 10'd50, 8'd120, 8'd90, 8'd60, 4'h5);
    send_command(CMD_F);
    send_ticks(30);
    send_command(CMD_S);
    send_command(CMD_R);
    send_ticks(10);
    configure(8'd7, 10'd12, 8'd120, 8'd90, 8'd60, 4'h5);
    send_ticks(3);
  endtask

  task automatic test_longest_period();
    configure(8'd255, 10'd1000, 8'd255, 8'd0, 8'd0, 4'hA);
    send_command(CMD_B);
    send_ticks(40);
  endtask

  task automatic run_random_phase(input int n_items);
    int stop_at;
    int run_len;
    logic [7:0] letter;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(19))
        0: send_command(8'($urandom));
        1: send_command($urandom_range(1) ? CMD_S : (CMD_S | CASE_DELTA));
        2: wait_drained();
        default: begin
          letter = pick_motion($urandom_range(9));
          if ($urandom_range(1)) begin
            letter = letter | CASE_DELTA;
          end
          send_command(letter);
          run_len = $urandom_range(0, 3 * int'(slew_period) + 3);
          if (run_len > 40) begin
            run_len = 40;
          end
          send_ticks(run_len);
        end
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 9;
    receiver_idle_pct = 62;
    test_reset_defaults();
    test_command_decode();
    configure(8'd1, 10'd1, 8'($urandom), 8'($urandom), 8'($urandom), 4'hF);
    run_random_phase(60);
    configure(8'd0, 10'd0, 8'd255, 8'd255, 8'd255, 4'($urandom));
    run_random_phase(60);

    sender_idle_pct = 62;
    receiver_idle_pct = 9;
    test_period_change();
    configure(8'd255, 10'd2, 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
    run_random_phase(60);
    configure(8'($urandom_range(1, 255)), 10'($urandom_range(1, 8)), 8'($urandom),
              8'($urandom), 8'($urandom), 4'($urandom));
    run_random_phase(60);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_longest_period();
    configure(8'($urandom_range(1, 255)), 10'd3, 8'd0, 8'd255, 8'd0, 4'h0);
    run_random_phase(60);
    configure(RST_RAMP_STEP, RST_RAMP_PERIOD_MS, RST_SPEED_DEFAULT, RST_ROTATE_SPEED,
              RST_DIAGONAL_SPEED, RST_REVERSED_MASK);
    run_random_phase(60);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_duties.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fwprc_pkg.sv
rtl/core/fwprc_wheel.sv
rtl/core/four_wheel_pwm_ramp_controller.sv
sim/tb.sv
